### rtl/sxmap_pkg.sv
// sxmap_pkg: types, constants and helpers for the STUN XOR-MAPPED-ADDRESS parser.
// No dependencies; used by sxmap_cfg, sxmap_parser and the top level.
package sxmap_pkg;

    localparam int MAX_MESSAGE_BYTES = 2048;
    localparam int OFFSET_W          = $clog2(MAX_MESSAGE_BYTES + 1);

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [4:0]  ID_FIRST        = 5'd8;
    localparam logic [4:0]  HEADER_LAST     = 5'd19;
    localparam logic [31:0] MAGIC_COOKIE    = 32'h2112_A442;
    localparam logic [15:0] PORT_MASK       = 16'h2112;
    localparam logic [15:0] XOR_MAPPED_TYPE = 16'h0020;
    localparam logic [7:0]  FAMILY_V4       = 8'h01;
    localparam logic [7:0]  FAMILY_V6       = 8'h02;

    localparam logic [1:0]  FAM_CODE_V4    = 2'd0;
    localparam logic [1:0]  FAM_CODE_V6    = 2'd1;
    localparam logic [1:0]  FAM_CODE_OTHER = 2'd2;

    typedef enum logic [1:0] {
        PH_HEADER   = 2'd0,
        PH_ATTR_HDR = 2'd1,
        PH_ATTR_VAL = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        REG_TXN_ID_HIGH = 2'd0,
        REG_TXN_ID_MID  = 2'd1,
        REG_TXN_ID_LOW  = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic        id_match;
        logic        address_found;
        logic [1:0]  addr_family;
        logic [15:0] mapped_port;
        logic [31:0] mapped_ipv4;
        logic        truncated;
    } result_t;

    function automatic logic [1:0] family_code(input logic [7:0] b);
        logic [1:0] code;
        if (b == FAMILY_V4) begin
            code = FAM_CODE_V4;
        end else if (b == FAMILY_V6) begin
            code = FAM_CODE_V6;
        end else begin
            code = FAM_CODE_OTHER;
        end
        return code;
    endfunction

endpackage

### rtl/sxmap_if.sv
// sxmap_msg_if / sxmap_res_if: valid/ready channels for message bytes and results.
// No dependencies.
interface sxmap_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_message;

    modport source (output valid, output data_byte, output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface sxmap_res_if;
    logic        valid;
    logic        ready;
    logic        id_match;
    logic        address_found;
    logic [1:0]  addr_family;
    logic [15:0] mapped_port;
    logic [31:0] mapped_ipv4;
    logic        truncated;

    modport source (output valid, output id_match, output address_found,
                    output addr_family, output mapped_port, output mapped_ipv4,
                    output truncated, input ready);
    modport sink   (input valid, input id_match, input address_found,
                    input addr_family, input mapped_port, input mapped_ipv4,
                    input truncated, output ready);
endinterface

### rtl/sxmap_cfg.sv
// sxmap_cfg: APB register file holding the 96-bit expected transaction ID.
// Depends on sxmap_pkg.
module sxmap_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sxmap_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [sxmap_pkg::APB_DATA_W-1:0] pwdata,
    output logic [sxmap_pkg::APB_DATA_W-1:0] prdata,
    output logic                             pready,
    output logic [95:0]                      txn_id
);

    logic [31:0] id_high_reg;
    logic [31:0] id_mid_reg;
    logic [31:0] id_low_reg;
    logic        wr_en;
    sxmap_pkg::reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = sxmap_pkg::reg_idx_t'(paddr[3:2]);
    assign txn_id = {id_high_reg, id_mid_reg, id_low_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_high_reg <= '0;
            id_mid_reg  <= '0;
            id_low_reg  <= '0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                sxmap_pkg::REG_TXN_ID_HIGH: id_high_reg <= pwdata;
                sxmap_pkg::REG_TXN_ID_MID:  id_mid_reg  <= pwdata;
                sxmap_pkg::REG_TXN_ID_LOW:  id_low_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            sxmap_pkg::REG_TXN_ID_HIGH: prdata = id_high_reg;
            sxmap_pkg::REG_TXN_ID_MID:  prdata = id_mid_reg;
            sxmap_pkg::REG_TXN_ID_LOW:  prdata = id_low_reg;
            default:                    prdata = '0;
        endcase
    end

endmodule

### rtl/sxmap_parser.sv
// sxmap_parser: per-byte header/TLV walk state and result formation for one message.
// Depends on sxmap_pkg.
module sxmap_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           data_byte,
    input  logic                 end_of_message,
    input  logic [95:0]          txn_id,
    output sxmap_pkg::result_t   res
);

    logic [sxmap_pkg::OFFSET_W-1:0] offset_reg, offset_next, offset_upd;
    logic                           id_eq_reg, id_eq_next, id_eq_upd;
    sxmap_pkg::phase_t              phase_reg, phase_next, phase_upd;
    logic [15:0]                    type_reg, type_next, type_upd;
    logic [15:0]                    left_reg, left_next, left_upd;
    logic [3:0]                     vidx_reg, vidx_next, vidx_upd;
    logic                           found_reg, found_next, found_upd;
    logic [1:0]                     fam_reg, fam_next, fam_upd;
    logic [15:0]                    port_reg, port_next, port_upd;
    logic [31:0]                    addr_reg, addr_next, addr_upd;
    logic [1:0]                     pfam_reg, pfam_upd;
    logic [15:0]                    pport_reg, pport_upd;
    logic [31:0]                    paddr_reg, paddr_upd;

    logic [4:0]  id_k;
    logic [7:0]  id_byte;
    logic [15:0] len_shift;
    logic        decode;
    logic        header_done;

    assign id_k    = offset_reg[4:0] - sxmap_pkg::ID_FIRST;
    assign id_byte = txn_id[8'd95 - {id_k[3:0], 3'b000} -: 8];

    // byte update
    always_comb
    begin
        offset_upd = offset_reg;
        id_eq_upd  = id_eq_reg;
        phase_upd  = phase_reg;
        type_upd   = type_reg;
        left_upd   = left_reg;
        vidx_upd   = vidx_reg;
        found_upd  = found_reg;
        fam_upd    = fam_reg;
        port_upd   = port_reg;
        addr_upd   = addr_reg;
        pfam_upd   = pfam_reg;
        pport_upd  = pport_reg;
        paddr_upd  = paddr_reg;
        len_shift  = {((vidx_reg == 4'd2) ? 8'h00 : left_reg[7:0]), data_byte};
        decode     = (type_reg == sxmap_pkg::XOR_MAPPED_TYPE) && id_eq_reg
                     && (vidx_reg < 4'd8);
        if (offset_reg < sxmap_pkg::OFFSET_W'(sxmap_pkg::MAX_MESSAGE_BYTES))
        begin
            offset_upd = offset_reg + 1'b1;
            unique case (phase_reg)
                sxmap_pkg::PH_HEADER:
                begin
                    if (offset_reg >= sxmap_pkg::OFFSET_W'(sxmap_pkg::ID_FIRST)
                        && id_byte != data_byte)
                    begin
                        id_eq_upd = 1'b0;
                    end
                    if (offset_reg[4:0] == sxmap_pkg::HEADER_LAST)
                    begin
                        phase_upd = sxmap_pkg::PH_ATTR_HDR;
                        vidx_upd  = '0;
                    end
                end
                sxmap_pkg::PH_ATTR_HDR:
                begin
                    if (vidx_reg < 4'd2)
                    begin
                        type_upd = {type_reg[7:0], data_byte};
                        if (vidx_reg == 4'd0)
                        begin
                            left_upd = '0;
                        end
                    end
                    else
                    begin
                        left_upd = len_shift;
                    end
                    vidx_upd = vidx_reg + 1'b1;
                    if (vidx_reg == 4'd3)
                    begin
                        vidx_upd  = '0;
                        phase_upd = (len_shift == 16'd0) ? sxmap_pkg::PH_ATTR_HDR
                                                         : sxmap_pkg::PH_ATTR_VAL;
                    end
                end
                sxmap_pkg::PH_ATTR_VAL:
                begin
                    if (decode)
                    begin
                        if (vidx_reg == 4'd1)
                        begin
                            pfam_upd = sxmap_pkg::family_code(data_byte);
                        end
                        else if (vidx_reg == 4'd2 || vidx_reg == 4'd3)
                        begin
                            pport_upd = {pport_reg[7:0], data_byte};
                        end
                        else if (vidx_reg >= 4'd4)
                        begin
                            paddr_upd = {paddr_reg[23:0], data_byte};
                        end
                        if (vidx_reg == 4'd7)
                        begin
                            fam_upd   = pfam_reg;
                            port_upd  = pport_reg ^ sxmap_pkg::PORT_MASK;
                            addr_upd  = {paddr_reg[23:0], data_byte} ^ sxmap_pkg::MAGIC_COOKIE;
                            found_upd = 1'b1;
                        end
                    end
                    if (vidx_reg < 4'd8)
                    begin
                        vidx_upd = vidx_reg + 1'b1;
                    end
                    left_upd = left_reg - 1'b1;
                    if (left_reg == 16'd1)
                    begin
                        phase_upd = sxmap_pkg::PH_ATTR_HDR;
                        vidx_upd  = '0;
                        type_upd  = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // result from the state after this byte
    always_comb
    begin
        header_done       = (phase_upd != sxmap_pkg::PH_HEADER);
        res.id_match      = header_done && id_eq_upd;
        res.address_found = found_upd;
        res.addr_family   = found_upd ? fam_upd  : 2'd0;
        res.mapped_port   = found_upd ? port_upd : 16'd0;
        res.mapped_ipv4   = found_upd ? addr_upd : 32'd0;
        res.truncated     = !header_done
                            || (phase_upd == sxmap_pkg::PH_ATTR_HDR && vidx_upd != 4'd0)
                            || (phase_upd == sxmap_pkg::PH_ATTR_VAL && left_upd != 16'd0);
    end

    // message boundary returns everything to reset values
    always_comb
    begin
        offset_next = offset_reg;
        id_eq_next  = id_eq_reg;
        phase_next  = phase_reg;
        type_next   = type_reg;
        left_next   = left_reg;
        vidx_next   = vidx_reg;
        found_next  = found_reg;
        fam_next    = fam_reg;
        port_next   = port_reg;
        addr_next   = addr_reg;
        if (accept)
        begin
            if (end_of_message)
            begin
                offset_next = '0;
                id_eq_next  = 1'b1;
                phase_next  = sxmap_pkg::PH_HEADER;
                type_next   = '0;
                left_next   = '0;
                vidx_next   = '0;
                found_next  = 1'b0;
                fam_next    = '0;
                port_next   = '0;
                addr_next   = '0;
            end
            else
            begin
                offset_next = offset_upd;
                id_eq_next  = id_eq_upd;
                phase_next  = phase_upd;
                type_next   = type_upd;
                left_next   = left_upd;
                vidx_next   = vidx_upd;
                found_next  = found_upd;
                fam_next    = fam_upd;
                port_next   = port_upd;
                addr_next   = addr_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            id_eq_reg  <= 1'b1;
            phase_reg  <= sxmap_pkg::PH_HEADER;
            type_reg   <= '0;
            left_reg   <= '0;
            vidx_reg   <= '0;
            found_reg  <= 1'b0;
            fam_reg    <= '0;
            port_reg   <= '0;
            addr_reg   <= '0;
        end
        else
        begin
            offset_reg <= offset_next;
            id_eq_reg  <= id_eq_next;
            phase_reg  <= phase_next;
            type_reg   <= type_next;
            left_reg   <= left_next;
            vidx_reg   <= vidx_next;
            found_reg  <= found_next;
            fam_reg    <= fam_next;
            port_reg   <= port_next;
            addr_reg   <= addr_next;
        end
    end

    // pending copies are fully rewritten before every commit
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pfam_reg  <= pfam_upd;
            pport_reg <= pport_upd;
            paddr_reg <= paddr_upd;
        end
    end

endmodule

### rtl/stun_xor_mapped_address_parser_core.sv
// stun_xor_mapped_address_parser_core: top level of the STUN XOR-MAPPED-ADDRESS parser.
// Depends on sxmap_pkg, sxmap_if, sxmap_cfg and sxmap_parser.
//
//   channel  kind         transaction payload
//   msg      valid/ready  data_byte, end_of_message
//   result   valid/ready  id_match, address_found, addr_family, mapped_port,
//                         mapped_ipv4, truncated
//   apb      psel/penable txn_id_high, txn_id_mid, txn_id_low at 0x0, 0x4, 0x8
//
// One byte per cycle while msg.ready is high; the parse state updates at the accepting edge.
// A result appears in the cycle after its final byte is accepted, from the result register.
// msg.ready drops only while a result is held and result.ready is low.
// Reset clears parse state, ID registers and the result valid flag.
module stun_xor_mapped_address_parser_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sxmap_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [sxmap_pkg::APB_DATA_W-1:0] pwdata,
    output logic [sxmap_pkg::APB_DATA_W-1:0] prdata,
    output logic                             pready,
    sxmap_msg_if.sink                        msg,
    sxmap_res_if.source                      result
);

    logic [95:0]        txn_id;
    logic               accept;
    logic               emit;
    sxmap_pkg::result_t res_comb;
    sxmap_pkg::result_t res_reg;
    logic               out_valid_reg, out_valid_next;

    sxmap_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .txn_id  (txn_id)
    );

    sxmap_parser u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .data_byte      (msg.data_byte),
        .end_of_message (msg.end_of_message),
        .txn_id         (txn_id),
        .res            (res_comb)
    );

    assign msg.ready = !out_valid_reg || result.ready;
    assign accept    = msg.valid && msg.ready;
    assign emit      = accept && msg.end_of_message;

    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_reg <= res_comb;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.id_match      = res_reg.id_match;
    assign result.address_found = res_reg.address_found;
    assign result.addr_family   = res_reg.addr_family;
    assign result.mapped_port   = res_reg.mapped_port;
    assign result.mapped_ipv4   = res_reg.mapped_ipv4;
    assign result.truncated     = res_reg.truncated;

endmodule

### rtl/sxmap_checker.sv
// sxmap_checker: port-level assertions for the STUN parser top level, plus its bind.
// Depends on stun_xor_mapped_address_parser_core.
module sxmap_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        msg_valid,
    input logic        msg_ready,
    input logic        msg_end,
    input logic        res_valid,
    input logic        res_ready,
    input logic        id_match,
    input logic        address_found,
    input logic [1:0]  addr_family,
    input logic [15:0] mapped_port,
    input logic [31:0] mapped_ipv4,
    input logic        truncated
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(mapped_ipv4)
            && $stable(mapped_port) && $stable(id_match) && $stable(truncated))
        else $error("stalled result changed");

    a_final_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && msg_ready && msg_end |=> res_valid)
        else $error("final byte produced no result");

    a_no_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !address_found |->
            addr_family == 2'd0 && mapped_port == 16'd0 && mapped_ipv4 == 32'd0)
        else $error("address fields set without an address");

    a_found_needs_match: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && address_found |-> id_match && addr_family != 2'd3)
        else $error("address decoded without an ID match");

    a_short_header: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !id_match && !truncated |-> !address_found)
        else $error("inconsistent result flags");

endmodule

bind stun_xor_mapped_address_parser_core sxmap_checker u_sxmap_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .msg_valid     (msg.valid),
    .msg_ready     (msg.ready),
    .msg_end       (msg.end_of_message),
    .res_valid     (result.valid),
    .res_ready     (result.ready),
    .id_match      (result.id_match),
    .address_found (result.address_found),
    .addr_family   (result.addr_family),
    .mapped_port   (result.mapped_port),
    .mapped_ipv4   (result.mapped_ipv4),
    .truncated     (result.truncated)
);
